@@ design/rle4_pkg.sv @@
// ============================================================================
// rle4_pkg: shared types and constants of the 4bpp run-length decoder
// Holds register indexes, reset values, controller command/status structs.
// ============================================================================
`default_nettype none

package rle4_pkg;

    // Geometry limits used as parameter defaults
    localparam int DEF_MAX_ROW_BYTES = 1024;
    localparam int DEF_MAX_ROWS      = 1024;

    // Configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_REGS   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BYTES  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 8'd3;

    // Register widths and reset values
    localparam int BASE_W   = 32;
    localparam int STRIDE_W = 16;
    localparam int GEOM_W   = 11;

    localparam logic [BASE_W-1:0]   RST_FRAME_BASE = 32'd0;
    localparam logic [STRIDE_W-1:0] RST_ROW_STRIDE = 16'd512;
    localparam logic [GEOM_W-1:0]   RST_ROW_BYTES  = 11'd120;
    localparam logic [GEOM_W-1:0]   RST_ROW_COUNT  = 11'd160;

    // Payload widths
    localparam int BYTE_W  = 8;
    localparam int COLOR_W = 4;
    localparam int LEN_W   = 16;
    localparam int OROW_W  = 10;
    localparam int ONIB_W  = 11;
    localparam int ADDR_W  = 32;

    // Run length source selection
    localparam logic [1:0] LEN_NONE   = 2'd0;
    localparam logic [1:0] LEN_NIBBLE = 2'd1;
    localparam logic [1:0] LEN_BYTE   = 2'd2;
    localparam logic [1:0] LEN_WIDE   = 2'd3;

    typedef struct packed {
        logic       init;        // restart frame
        logic       take_color;  // latch color nibble from the byte
        logic [1:0] len_sel;     // load run length from the byte
        logic       take_low;    // latch low count byte
        logic       check;       // capture product, update pixel budget
        logic       start_div;   // form address, seed divider
        logic       div_step;    // one restoring divide step
        logic       send;        // load result register, commit position
        logic       send_err;    // result is the malformed marker
    } rle4_cmd_t;

    typedef struct packed {
        logic hi_zero;    // code byte count nibble is zero
        logic byte_zero;  // whole byte is zero
        logic wide_zero;  // 16-bit count would be zero
        logic overrun;    // run longer than pixels left
        logic div_last;   // final divide step
        logic out_free;   // result register can take a new request
        logic cfg_hit;    // write to a defined register
    } rle4_sts_t;

endpackage

`default_nettype wire

@@ design/rle4_if.sv @@
// ============================================================================
// rle4 channel interfaces
// Valid/ready channels for stream bytes and run descriptors.
// ============================================================================
`default_nettype none

interface rle4_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rle4_run_if;
    logic        valid;
    logic        ready;
    logic [3:0]  run_color;
    logic [15:0] run_length;
    logic [9:0]  start_row;
    logic [10:0] start_nibble;
    logic [31:0] start_address;
    logic        frame_full;
    logic        malformed;

    modport source (output valid, output run_color, output run_length, output start_row,
                    output start_nibble, output start_address, output frame_full,
                    output malformed, input ready);
    modport sink   (input valid, input run_color, input run_length, input start_row,
                    input start_nibble, input start_address, input frame_full,
                    input malformed, output ready);
endinterface

`default_nettype wire

@@ design/rle_4bpp_run_decoder.sv @@
// ============================================================================
// rle_4bpp_run_decoder: 4bpp run-length stream to run descriptor decoder
// Parses code bytes and count escapes, emits one descriptor per run.
// ============================================================================
// Usage:
//   stream : one coded byte per request (valid/ready). Bytes that only
//            open an escape are taken with no stall of stream.
//   runs   : one descriptor per run (color, length, start row/column,
//            start byte address, frame_full, malformed).
//   cfg    : cfg_write/cfg_index/cfg_data; any write to a defined register
//            restarts the frame and closes stream for one cycle.
// Order: a byte that completes a run passes check, address, a divider
//   step per bit of column plus length, then the result register; an
//   error descriptor goes straight to the result register for a zero
//   wide count and after the check for an overrun.
//   Run bytes are paced by the bit-serial row/column divider: stream stays
//   closed until the run is sent, while bytes that only open an escape do not.
// Reset: geometry returns to its defaults and the pixel budget is loaded
//   in one cycle before stream opens.
// Stall: the result register holds while runs.ready is low; decoding of
//   the next byte goes on and waits only to load the register.
// After an error, bytes are taken and dropped until a write to a defined register.
// ============================================================================
`default_nettype none

module rle_4bpp_run_decoder #(
    parameter int MAX_ROW_BYTES = rle4_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = rle4_pkg::DEF_MAX_ROWS
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_write,
    input  wire  [rle4_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [rle4_pkg::CFG_DATA_W-1:0]  cfg_data,
    rle4_byte_if.sink                        stream,
    rle4_run_if.source                       runs
);
    import rle4_pkg::*;

    rle4_cmd_t cmd;
    rle4_sts_t sts;

    rle4_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (stream.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rle4_datapath #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES),
        .MAX_ROWS      (MAX_ROWS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stream_byte   (stream.stream_byte),
        .cmd           (cmd),
        .sts           (sts),
        .run_ready     (runs.ready),
        .run_valid     (runs.valid),
        .run_color     (runs.run_color),
        .run_length    (runs.run_length),
        .start_row     (runs.start_row),
        .start_nibble  (runs.start_nibble),
        .start_address (runs.start_address),
        .frame_full    (runs.frame_full),
        .malformed     (runs.malformed)
    );

endmodule

`default_nettype wire

@@ design/rle4_ctrl.sv @@
// ============================================================================
// rle4_ctrl: decoder controller
// Tracks the parse phase and the sticky error, sequences check, address,
// divide and send steps of each run.
// ============================================================================
`default_nettype none

module rle4_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  rle4_pkg::rle4_sts_t  sts,
    output rle4_pkg::rle4_cmd_t  cmd
);
    import rle4_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_ADDR  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_SEND  = 3'd5;

    localparam logic [1:0] PH_CODE  = 2'd0;
    localparam logic [1:0] PH_EXT8  = 2'd1;
    localparam logic [1:0] PH_LOW   = 2'd2;
    localparam logic [1:0] PH_HIGH  = 2'd3;

    logic [2:0] state_reg, state_next;
    logic [1:0] phase_reg, phase_next;
    logic       err_reg, err_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state, parse phase and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        err_next   = err_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                // drop bytes while the error is latched
                if (in_valid && !err_reg)
                begin
                    unique case (phase_reg)
                        PH_CODE:
                        begin
                            cmd.take_color = 1'b1;
                            if (!sts.hi_zero)
                            begin
                                cmd.len_sel = LEN_NIBBLE;
                                state_next  = ST_CHECK;
                            end
                            else
                            begin
                                phase_next = PH_EXT8;
                            end
                        end
                        PH_EXT8:
                        begin
                            if (!sts.byte_zero)
                            begin
                                cmd.len_sel = LEN_BYTE;
                                phase_next  = PH_CODE;
                                state_next  = ST_CHECK;
                            end
                            else
                            begin
                                phase_next = PH_LOW;
                            end
                        end
                        PH_LOW:
                        begin
                            cmd.take_low = 1'b1;
                            phase_next   = PH_HIGH;
                        end
                        PH_HIGH:
                        begin
                            phase_next = PH_CODE;
                            if (sts.wide_zero)
                            begin
                                err_next   = 1'b1;
                                state_next = ST_SEND;
                            end
                            else
                            begin
                                cmd.len_sel = LEN_WIDE;
                                state_next  = ST_CHECK;
                            end
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                if (sts.overrun)
                begin
                    err_next   = 1'b1;
                    state_next = ST_SEND;
                end
                else
                begin
                    cmd.check  = 1'b1;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                cmd.start_div = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                // hold until the result register is free
                if (sts.out_free)
                begin
                    cmd.send     = 1'b1;
                    cmd.send_err = err_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase

        // a register write restarts the frame
        if (sts.cfg_hit)
        begin
            state_next = ST_INIT;
            phase_next = PH_CODE;
            err_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            phase_reg <= PH_CODE;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

@@ design/rle4_datapath.sv @@
// ============================================================================
// rle4_datapath: decoder datapath
// Configuration registers, frame position, pixel budget, address multiply,
// restoring divider for the row advance and the result register.
// ============================================================================
`default_nettype none

module rle4_datapath #(
    parameter int MAX_ROW_BYTES = rle4_pkg::DEF_MAX_ROW_BYTES,
    parameter int MAX_ROWS      = rle4_pkg::DEF_MAX_ROWS
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_write,
    input  wire  [rle4_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [rle4_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire  [rle4_pkg::BYTE_W-1:0]         stream_byte,
    input  rle4_pkg::rle4_cmd_t                 cmd,
    output rle4_pkg::rle4_sts_t                 sts,
    input  wire                                 run_ready,
    output logic                                run_valid,
    output logic [rle4_pkg::COLOR_W-1:0]        run_color,
    output logic [rle4_pkg::LEN_W-1:0]          run_length,
    output logic [rle4_pkg::OROW_W-1:0]         start_row,
    output logic [rle4_pkg::ONIB_W-1:0]         start_nibble,
    output logic [rle4_pkg::ADDR_W-1:0]         start_address,
    output logic                                frame_full,
    output logic                                malformed
);
    import rle4_pkg::*;

    localparam int EB_W   = $clog2(MAX_ROW_BYTES + 1);
    localparam int ER_W   = $clog2(MAX_ROWS + 1);
    localparam int WID_W  = $clog2(2 * MAX_ROW_BYTES + 1);
    localparam int COL_W  = $clog2(2 * MAX_ROW_BYTES);
    localparam int ROW_W  = ER_W;
    localparam int PIX_W  = $clog2(2 * MAX_ROW_BYTES * MAX_ROWS + 1);
    localparam int CMP_W  = (PIX_W > LEN_W) ? PIX_W : LEN_W;
    localparam int TOT_W  = $clog2(2 * MAX_ROW_BYTES + 65535);
    localparam int CNT_W  = $clog2(TOT_W);
    localparam int PROD_W = ROW_W + STRIDE_W;
    localparam int GP_W   = EB_W + ER_W;

    // Configuration registers
    logic [BASE_W-1:0]   base_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [GEOM_W-1:0]   rbytes_reg;
    logic [GEOM_W-1:0]   rcount_reg;

    // Frame and run state
    logic [COLOR_W-1:0]  color_reg;
    logic [BYTE_W-1:0]   low_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [COL_W-1:0]    col_reg;
    logic [PIX_W-1:0]    rem_reg;
    logic [ADDR_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic                full_reg;

    // Divider
    logic [TOT_W-1:0]    dvd_reg;
    logic [WID_W-1:0]    part_reg;
    logic [CNT_W-1:0]    cnt_reg;

    logic [EB_W-1:0]     eff_bytes;
    logic [ER_W-1:0]     eff_rows;
    logic [WID_W-1:0]    width_px;
    logic [PIX_W-1:0]    frame_px;
    logic [WID_W:0]      shifted;
    logic                q_bit;
    logic [WID_W-1:0]    part_next;

    // Saturate geometry to the supported range
    always_comb
    begin
        priority if (rbytes_reg == '0)
            eff_bytes = EB_W'(1);
        else if (32'(rbytes_reg) > 32'(MAX_ROW_BYTES))
            eff_bytes = EB_W'(MAX_ROW_BYTES);
        else
            eff_bytes = EB_W'(rbytes_reg);

        priority if (rcount_reg == '0)
            eff_rows = ER_W'(1);
        else if (32'(rcount_reg) > 32'(MAX_ROWS))
            eff_rows = ER_W'(MAX_ROWS);
        else
            eff_rows = ER_W'(rcount_reg);
    end

    assign width_px = WID_W'({eff_bytes, 1'b0});
    assign frame_px = PIX_W'({GP_W'(eff_bytes) * GP_W'(eff_rows), 1'b0});

    // One restoring divide step
    assign shifted   = {part_reg, dvd_reg[TOT_W-1]};
    assign q_bit     = (shifted >= {1'b0, width_px});
    assign part_next = q_bit ? WID_W'(shifted - {1'b0, width_px}) : WID_W'(shifted);

    // Status toward the controller
    always_comb
    begin
        sts.hi_zero   = (stream_byte[7:4] == '0);
        sts.byte_zero = (stream_byte == '0);
        sts.wide_zero = (stream_byte == '0) && (low_reg == '0);
        sts.overrun   = (CMP_W'(len_reg) > CMP_W'(rem_reg));
        sts.div_last  = (cnt_reg == CNT_W'(TOT_W - 1));
        sts.out_free  = !run_valid || run_ready;
        sts.cfg_hit   = cfg_write && (32'(cfg_index) < 32'(NUM_REGS));
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= RST_FRAME_BASE;
            stride_reg <= RST_ROW_STRIDE;
            rbytes_reg <= RST_ROW_BYTES;
            rcount_reg <= RST_ROW_COUNT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_BASE: base_reg   <= cfg_data;
                REG_ROW_STRIDE: stride_reg <= cfg_data[STRIDE_W-1:0];
                REG_ROW_BYTES:  rbytes_reg <= cfg_data[GEOM_W-1:0];
                REG_ROW_COUNT:  rcount_reg <= cfg_data[GEOM_W-1:0];
                default:        ;
            endcase
        end
    end

    // Parse fields, pixel budget and frame position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
            low_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            rem_reg   <= '0;
        end
        else if (cmd.init)
        begin
            color_reg <= '0;
            low_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            rem_reg   <= frame_px;
        end
        else
        begin
            if (cmd.take_color)
                color_reg <= stream_byte[COLOR_W-1:0];
            if (cmd.take_low)
                low_reg <= stream_byte;
            if (cmd.check)
                rem_reg <= rem_reg - PIX_W'(len_reg);
            // advance position once the result goes out
            if (cmd.send && !cmd.send_err)
            begin
                row_reg <= row_reg + ROW_W'(dvd_reg);
                col_reg <= COL_W'(part_reg);
            end
        end
    end

    // Run length, address and divider
    always_ff @(posedge clk)
    begin
        unique case (cmd.len_sel)
            LEN_NIBBLE: len_reg <= LEN_W'(stream_byte[7:4]);
            LEN_BYTE:   len_reg <= LEN_W'(stream_byte);
            LEN_WIDE:   len_reg <= {stream_byte, low_reg};
            LEN_NONE:   ;
        endcase

        if (cmd.check)
        begin
            prod_reg <= ADDR_W'(PROD_W'(row_reg) * PROD_W'(stride_reg));
            full_reg <= (rem_reg == PIX_W'(len_reg));
        end

        if (cmd.start_div)
        begin
            addr_reg <= base_reg + prod_reg + ADDR_W'(col_reg >> 1);
            dvd_reg  <= TOT_W'(col_reg) + TOT_W'(len_reg);
            part_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg  <= {dvd_reg[TOT_W-2:0], q_bit};
            part_reg <= part_next;
            cnt_reg  <= cnt_reg + CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            run_valid <= 1'b0;
        else if (cmd.send)
            run_valid <= 1'b1;
        else if (run_ready)
            run_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.send)
        begin
            if (cmd.send_err)
            begin
                run_color     <= '0;
                run_length    <= '0;
                start_row     <= '0;
                start_nibble  <= '0;
                start_address <= '0;
                frame_full    <= 1'b0;
                malformed     <= 1'b1;
            end
            else
            begin
                run_color     <= color_reg;
                run_length    <= len_reg;
                start_row     <= OROW_W'(row_reg);
                start_nibble  <= ONIB_W'(col_reg);
                start_address <= addr_reg;
                frame_full    <= full_reg;
                malformed     <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ design/rle4_checker.sv @@
// ============================================================================
// rle4_checker: port-level assertions for the run decoder
// Watches configuration, stream and run channels of the top level.
// ============================================================================
`default_nettype none

module rle4_checker (
    input wire                          clk,
    input wire                          rst_n,
    input wire                          cfg_write,
    input wire [rle4_pkg::CFG_IDX_W-1:0] cfg_index,
    input wire                          in_ready,
    input wire                          run_valid,
    input wire                          run_ready,
    input wire [3:0]                    run_color,
    input wire [15:0]                   run_length,
    input wire [9:0]                    start_row,
    input wire [10:0]                   start_nibble,
    input wire [31:0]                   start_address,
    input wire                          frame_full,
    input wire                          malformed
);
    import rle4_pkg::*;

    // Hold a stalled result
    a_run_hold: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !run_ready |=> run_valid && $stable(run_length)
            && $stable(start_address) && $stable(malformed))
        else $error("stalled run descriptor changed");

    // Error descriptor carries nothing but the flag
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && malformed |-> run_color == 4'd0 && run_length == 16'd0
            && start_row == 10'd0 && start_nibble == 11'd0
            && start_address == 32'd0 && !frame_full)
        else $error("malformed descriptor has nonzero fields");

    // Good runs are never empty
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid && !malformed |-> run_length != 16'd0)
        else $error("good run with zero length");

    // Restart closes the stream for a cycle; undefined indexes are ignored
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write && (cfg_index < CFG_IDX_W'(NUM_REGS)) |=> !in_ready)
        else $error("stream open right after a register write");

endmodule

bind rle_4bpp_run_decoder rle4_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .in_ready      (stream.ready),
    .run_valid     (runs.valid),
    .run_ready     (runs.ready),
    .run_color     (runs.run_color),
    .run_length    (runs.run_length),
    .start_row     (runs.start_row),
    .start_nibble  (runs.start_nibble),
    .start_address (runs.start_address),
    .frame_full    (runs.frame_full),
    .malformed     (runs.malformed)
);

`default_nettype wire
